### rtl/lpd_pkg.sv
`timescale 1ns / 1ps

package lpd_pkg;

	// row geometry
	localparam int MAX_ROW_WIDTH = 512;
	localparam int IDX_W         = 9;
	localparam logic [IDX_W-1:0] COL_MAX = IDX_W'(MAX_ROW_WIDTH - 1);

	// pixel and threshold widths
	localparam int PIX_W = 8;
	localparam int SUM_W = PIX_W + 2;

	// depth of the row summary queue
	localparam int SUMQ_DEPTH = 2;
	localparam int SUMQ_PTR_W = $clog2(SUMQ_DEPTH);
	localparam int SUMQ_CNT_W = $clog2(SUMQ_DEPTH + 1);

	// configuration register reset values
	localparam logic [PIX_W-1:0] BLACK_THRESHOLD_RST = 8'd7;
	localparam logic [IDX_W-1:0] STRAIGHT_LOW_RST    = 9'd130;
	localparam logic [IDX_W-1:0] STRAIGHT_HIGH_RST   = 9'd190;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_BLACK_THRESHOLD = 2'd0,
		REG_STRAIGHT_LOW    = 2'd1,
		REG_STRAIGHT_HIGH   = 2'd2
	} reg_index_t;

	// steering codes
	typedef enum logic [1:0] {
		DIR_STRAIGHT = 2'd0,
		DIR_LEFT     = 2'd1,
		DIR_RIGHT    = 2'd2
	} steer_t;

	// current configuration
	typedef struct packed {
		logic [PIX_W-1:0] black_threshold;
		logic [IDX_W-1:0] straight_low;
		logic [IDX_W-1:0] straight_high;
	} cfg_t;

	// outcome of one row, handed from front to back
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
	} row_sum_t;

endpackage

### rtl/lpd_front.sv
`timescale 1ns / 1ps

module lpd_front import lpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [PIX_W-1:0] pixel_red,
	input  logic [PIX_W-1:0] pixel_green,
	input  logic [PIX_W-1:0] pixel_blue,
	input  logic             last_in_row,
	input  logic [PIX_W-1:0] black_threshold,
	output logic             sum_push,
	output row_sum_t         sum_word
);

	logic             prev_black_q;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [IDX_W-1:0] col_q;

	logic [SUM_W-1:0] rgb_sum;
	logic [SUM_W-1:0] thr_x3;
	logic             is_black;

	// floor(sum/3) < t is the same as sum < 3t
	assign rgb_sum  = SUM_W'(pixel_red) + SUM_W'(pixel_green) + SUM_W'(pixel_blue);
	assign thr_x3   = (SUM_W'(black_threshold) << 1) + SUM_W'(black_threshold);
	assign is_black = rgb_sum < thr_x3;

	// row summary leaves on the closing word
	assign sum_push       = accept && last_in_row;
	assign sum_word.found = found_q;
	assign sum_word.index = found_q ? found_idx_q : '0;

	// run tracking and column count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_black_q <= 1'b0;
			found_q      <= 1'b0;
			found_idx_q  <= '0;
			col_q        <= '0;
		end else if (accept) begin
			if (last_in_row) begin
				prev_black_q <= 1'b0;
				found_q      <= 1'b0;
				found_idx_q  <= '0;
				col_q        <= '0;
			end else begin
				if (!found_q) begin
					if (is_black) begin
						if (prev_black_q) begin
							found_q     <= 1'b1;
							found_idx_q <= col_q;
						end else begin
							prev_black_q <= 1'b1;
						end
					end else begin
						prev_black_q <= 1'b0;
					end
				end
				if (col_q < COL_MAX) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/lpd_sum_queue.sv
`timescale 1ns / 1ps

module lpd_sum_queue import lpd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  row_sum_t wr_word,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output row_sum_t rd_word
);

	row_sum_t                mem_q [SUMQ_DEPTH];
	logic [SUMQ_PTR_W-1:0]   wr_ptr_q;
	logic [SUMQ_PTR_W-1:0]   rd_ptr_q;
	logic [SUMQ_CNT_W-1:0]   count_q;
	logic                    do_push;
	logic                    do_pop;

	assign full    = count_q == SUMQ_CNT_W'(SUMQ_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_word = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == SUMQ_PTR_W'(SUMQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == SUMQ_PTR_W'(SUMQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/lpd_back.sv
`timescale 1ns / 1ps

module lpd_back import lpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sum_empty,
	input  row_sum_t         sum_word,
	output logic             sum_pop,
	input  logic [IDX_W-1:0] straight_low,
	input  logic [IDX_W-1:0] straight_high,
	input  logic             pop,
	output logic             empty,
	output logic [1:0]       steer_direction,
	output logic             line_found,
	output logic [IDX_W-1:0] first_black_index
);

	logic             valid_q;
	steer_t           dir_q;
	logic             found_q;
	logic [IDX_W-1:0] idx_q;
	steer_t           dir_next;
	logic             load;

	// steering decision: no line steers left, else the straight window is checked first
	always_comb begin
		if (!sum_word.found) begin
			dir_next = DIR_LEFT;
		end else if (straight_low < sum_word.index && sum_word.index < straight_high) begin
			dir_next = DIR_STRAIGHT;
		end else if (sum_word.index <= straight_low) begin
			dir_next = DIR_LEFT;
		end else begin
			dir_next = DIR_RIGHT;
		end
	end

	// output register refills as soon as it drains
	assign load    = !sum_empty && (!valid_q || pop);
	assign sum_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dir_q   <= dir_next;
			found_q <= sum_word.found;
			idx_q   <= sum_word.index;
		end
	end

	assign empty             = !valid_q;
	assign steer_direction   = dir_q;
	assign line_found        = found_q;
	assign first_black_index = idx_q;

endmodule

### rtl/line_position_detector_unit.sv
`timescale 1ns / 1ps

// Row line detector: push one RGB pixel per clock while full is low, marking
// the closing word of each row with last_in_row; that word is not examined
// and yields one result (steer direction, found flag, column of the second
// pixel of the first dark pair). Pixels are taken at one per cycle, with no
// gaps while full is low. An accepted closing word writes its row summary
// into the summary queue; the output register loads it once it is free.
// The two-entry summary queue plus the output register hold up to three row
// results while the reader stalls; full rises only once all of them are taken.
// Registers: index 0 dark threshold, 1 straight low bound, 2 straight high
// bound; write them only while the block is idle.

module line_position_detector_unit import lpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// pixel side
	input  logic             push,
	output logic             full,
	input  logic [PIX_W-1:0] pixel_red,
	input  logic [PIX_W-1:0] pixel_green,
	input  logic [PIX_W-1:0] pixel_blue,
	input  logic             last_in_row,
	// result side
	output logic             empty,
	input  logic             pop,
	output logic [1:0]       steer_direction,
	output logic             line_found,
	output logic [IDX_W-1:0] first_black_index,
	// configuration writes
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [IDX_W-1:0] cfg_data
);

	cfg_t     cfg_q;
	logic     accept;
	logic     sum_push;
	logic     sum_pop;
	logic     sum_empty;
	row_sum_t sum_wr;
	row_sum_t sum_rd;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.black_threshold <= BLACK_THRESHOLD_RST;
			cfg_q.straight_low    <= STRAIGHT_LOW_RST;
			cfg_q.straight_high   <= STRAIGHT_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_BLACK_THRESHOLD: cfg_q.black_threshold <= cfg_data[PIX_W-1:0];
				REG_STRAIGHT_LOW:    cfg_q.straight_low    <= cfg_data;
				REG_STRAIGHT_HIGH:   cfg_q.straight_high   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input word accepted
	assign accept = push && !full;

	lpd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.pixel_red       (pixel_red),
		.pixel_green     (pixel_green),
		.pixel_blue      (pixel_blue),
		.last_in_row     (last_in_row),
		.black_threshold (cfg_q.black_threshold),
		.sum_push        (sum_push),
		.sum_word        (sum_wr)
	);

	lpd_sum_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (sum_push),
		.wr_word (sum_wr),
		.full    (full),
		.pop     (sum_pop),
		.empty   (sum_empty),
		.rd_word (sum_rd)
	);

	lpd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.sum_empty         (sum_empty),
		.sum_word          (sum_rd),
		.sum_pop           (sum_pop),
		.straight_low      (cfg_q.straight_low),
		.straight_high     (cfg_q.straight_high),
		.pop               (pop),
		.empty             (empty),
		.steer_direction   (steer_direction),
		.line_found        (line_found),
		.first_black_index (first_black_index)
	);

endmodule

### bench/line_position_detector_unit_tb.sv
`timescale 1ns / 1ps

module line_position_detector_unit_tb;
	import lpd_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int LONG_HOLD   = 80;
	localparam int MAX_REPORTS = 40;

	// one pixel word as pushed into the block
	typedef struct {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             last;
	} pixel_word_t;

	// one row decision as read out of the block
	typedef struct {
		steer_t           dir;
		logic             found;
		logic [IDX_W-1:0] index;
	} row_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	logic [PIX_W-1:0] pixel_red = '0;
	logic [PIX_W-1:0] pixel_green = '0;
	logic [PIX_W-1:0] pixel_blue = '0;
	logic             last_in_row = 1'b0;
	logic             empty;
	logic             pop = 1'b0;
	logic [1:0]       steer_direction;
	logic             line_found;
	logic [IDX_W-1:0] first_black_index;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = '0;
	logic [IDX_W-1:0] cfg_data = '0;

	line_position_detector_unit DUT (.*);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the row tracker and its registers
	logic [PIX_W-1:0] thr_cfg  = BLACK_THRESHOLD_RST;
	logic [IDX_W-1:0] low_cfg  = STRAIGHT_LOW_RST;
	logic [IDX_W-1:0] high_cfg = STRAIGHT_HIGH_RST;
	logic             prev_dark = 1'b0;
	logic             seen_pair = 1'b0;
	logic [IDX_W-1:0] pair_col = '0;
	logic [IDX_W-1:0] col = '0;

	pixel_word_t pending_pixels[$];
	row_result_t expected_rows[$];
	row_result_t want;
	pixel_word_t next_pixel;

	int  mismatches = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  hold_left = 0;
	int  tx_style = 0;
	int  rx_style = 0;
	int  quiet = 0;
	int  phase_words = 0;
	bit  hold_req = 1'b0;
	bit  hold_ack = 1'b0;
	logic pix_taken = 1'b0;
	logic row_taken = 1'b0;

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_REPORTS)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// advance the shadow tracker by one accepted word
	task automatic track_pixel(input pixel_word_t w);
		int gray;
		row_result_t res;
		if (w.last) begin
			res.found = seen_pair;
			res.index = seen_pair ? pair_col : '0;
			if (!seen_pair)
				res.dir = DIR_LEFT;
			else if (low_cfg < res.index && res.index < high_cfg)
				res.dir = DIR_STRAIGHT;
			else if (res.index <= low_cfg)
				res.dir = DIR_LEFT;
			else
				res.dir = DIR_RIGHT;
			expected_rows.push_back(res);
			prev_dark = 1'b0;
			seen_pair = 1'b0;
			pair_col  = '0;
			col       = '0;
		end else begin
			if (!seen_pair) begin
				gray = (int'(w.red) + int'(w.green) + int'(w.blue)) / 3;
				if (gray < int'(thr_cfg)) begin
					if (prev_dark) begin
						seen_pair = 1'b1;
						pair_col  = col;
					end else begin
						prev_dark = 1'b1;
					end
				end else begin
					prev_dark = 1'b0;
				end
			end
			if (col != COL_MAX)
				col = col + 1'b1;
		end
	endtask

	function automatic int draw_gap(input int style);
		if (style == 0)
			return 0;
		if (style == 1)
			return $urandom_range(16, 0);
		return ($urandom_range(7, 0) == 0) ? $urandom_range(16, 1) : 0;
	endfunction

	// split a component sum into three bytes
	function automatic pixel_word_t pixel_with_sum(input int total);
		pixel_word_t w;
		int rest;
		w.red   = PIX_W'($urandom_range(total < 255 ? total : 255,
			total > 510 ? total - 510 : 0));
		rest    = total - int'(w.red);
		w.green = PIX_W'($urandom_range(rest < 255 ? rest : 255, rest > 255 ? rest - 255 : 0));
		w.blue  = PIX_W'(rest - int'(w.green));
		w.last  = 1'b0;
		return w;
	endfunction

	// dark or light pixel under the current threshold, often right at the boundary
	function automatic pixel_word_t shade(input bit dark);
		int edge_sum;
		int total;
		edge_sum = 3 * int'(thr_cfg);
		if (dark && edge_sum > 0) begin
			if ($urandom_range(1, 0))
				total = edge_sum - 1 - $urandom_range(2, 0);
			else
				total = $urandom_range(edge_sum - 1, 0);
			if (total < 0)
				total = 0;
		end else begin
			if ($urandom_range(1, 0))
				total = edge_sum + $urandom_range(2, 0);
			else
				total = $urandom_range(765, edge_sum);
			if (total > 765)
				total = 765;
		end
		return pixel_with_sum(total);
	endfunction

	task automatic queue_word(input int r, input int g, input int b, input bit last);
		pixel_word_t w;
		w.red   = PIX_W'(r);
		w.green = PIX_W'(g);
		w.blue  = PIX_W'(b);
		w.last  = last;
		pending_pixels.push_back(w);
		phase_words++;
	endtask

	// a row of body pixels, a dark pair ending at pair_at (none if negative), then the closing word
	task automatic queue_row(input int body, input int pair_at, input bit noisy);
		pixel_word_t w;
		int c;
		for (c = 0; c < body; c++) begin
			if (c == pair_at || c == pair_at - 1) begin
				w = shade(1'b1);
			end else if (noisy || (pair_at >= 0 && c > pair_at)) begin
				case ($urandom_range(4, 0))
					0, 1: w = shade(1'b1);
					2, 3: w = shade(1'b0);
					default: w = pixel_with_sum($urandom_range(765, 0));
				endcase
			end else begin
				w = shade(1'b0);
			end
			pending_pixels.push_back(w);
		end
		queue_word($urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(255, 0), 1'b1);
		phase_words += body;
	endtask

	// wait until every word went in and every row came out
	task automatic drain();
		while (pending_pixels.size() != 0 || push || expected_rows.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		phase_words = 0;
	endtask

	task automatic write_reg(input reg_index_t which, input logic [IDX_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (which)
			REG_BLACK_THRESHOLD: thr_cfg = value[PIX_W-1:0];
			REG_STRAIGHT_LOW:    low_cfg = value;
			REG_STRAIGHT_HIGH:   high_cfg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// pixel acceptance feeds the shadow tracker
	always @(posedge clk) begin
		pix_taken <= arst_n && push && !full;
		if (arst_n && push && !full) begin
			next_pixel.red   = pixel_red;
			next_pixel.green = pixel_green;
			next_pixel.blue  = pixel_blue;
			next_pixel.last  = last_in_row;
			track_pixel(next_pixel);
		end
	end

	// pixel driver
	always @(negedge clk) begin
		if (arst_n && (!push || pix_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				push <= 1'b0;
			end else if (pending_pixels.size() != 0) begin
				next_pixel = pending_pixels.pop_front();
				push        <= 1'b1;
				pixel_red   <= next_pixel.red;
				pixel_green <= next_pixel.green;
				pixel_blue  <= next_pixel.blue;
				last_in_row <= next_pixel.last;
				tx_gap = draw_gap(tx_style);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		row_taken <= arst_n && pop && !empty;
		if (arst_n && pop && !empty) begin
			if (expected_rows.size() == 0) begin
				report_mismatch("row result with nothing expected");
			end else begin
				want = expected_rows.pop_front();
				if (steer_direction !== want.dir)
					report_mismatch($sformatf("steer_direction %0d, expected %0d",
						steer_direction, want.dir));
				if (line_found !== want.found)
					report_mismatch($sformatf("line_found %0b, expected %0b",
						line_found, want.found));
				if (first_black_index !== want.index)
					report_mismatch($sformatf("first_black_index %0d, expected %0d",
						first_black_index, want.index));
			end
		end
	end

	// result reader with random stalls and one long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_ack) begin
			hold_left = LONG_HOLD;
			hold_ack  = 1'b1;
		end
		if (row_taken)
			rx_gap = draw_gap(rx_style);
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (rx_gap > 0) begin
			if (!empty)
				rx_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("line_position_detector_unit verification failed");
			$finish;
		end
	end

	initial begin
		int ph;
		int target;
		int lo;
		int hi;
		logic [PIX_W-1:0] thr;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset thresholds: lone closing word, dark pairs, gray boundary
		queue_word(255, 255, 255, 1'b1);
		queue_word(0, 0, 0, 1'b0);
		queue_word(0, 0, 0, 1'b0);
		queue_word(0, 0, 0, 1'b1);
		queue_word(255, 255, 255, 1'b0);
		queue_word(0, 0, 0, 1'b0);
		queue_word(255, 255, 255, 1'b0);
		queue_word(0, 0, 0, 1'b0);
		queue_word(0, 0, 0, 1'b0);
		queue_word(0, 0, 0, 1'b1);
		queue_word(6, 7, 7, 1'b0);
		queue_word(7, 7, 7, 1'b0);
		queue_word(6, 7, 7, 1'b0);
		queue_word(7, 6, 7, 1'b0);
		queue_word(255, 0, 0, 1'b1);
		drain();

		// narrow straight window: left, straight, right, and more dark after the pair
		write_reg(REG_BLACK_THRESHOLD, 9'd7);
		write_reg(REG_STRAIGHT_LOW, 9'd2);
		write_reg(REG_STRAIGHT_HIGH, 9'd5);
		queue_word(0, 0, 0, 1'b0);
		queue_word(0, 0, 0, 1'b0);
		queue_word(0, 0, 0, 1'b1);
		queue_word(90, 90, 90, 1'b0);
		queue_word(90, 90, 90, 1'b0);
		queue_word(1, 2, 3, 1'b0);
		queue_word(3, 2, 1, 1'b0);
		queue_word(0, 0, 0, 1'b0);
		queue_word(0, 0, 0, 1'b1);
		queue_word(200, 0, 0, 1'b0);
		queue_word(0, 200, 0, 1'b0);
		queue_word(0, 0, 200, 1'b0);
		queue_word(30, 30, 30, 1'b0);
		queue_word(0, 0, 0, 1'b0);
		queue_word(0, 0, 0, 1'b0);
		queue_word(0, 0, 0, 1'b1);
		drain();

		// random phases, each under its own register setting
		for (ph = 1; ph <= 12; ph++) begin
			thr = (ph == 1) ? 8'd0 : (ph == 2 || ph == 3) ? 8'd255 :
				PIX_W'($urandom_range(255, 1));
			lo  = (ph == 2) ? 511 : (ph == 1 || ph == 3) ? 0 : $urandom_range(40, 0);
			hi  = (ph == 1) ? 511 : (ph == 2 || ph == 3) ? 0 : $urandom_range(50, 0);
			write_reg(REG_STRAIGHT_HIGH, IDX_W'(hi));
			write_reg(REG_BLACK_THRESHOLD, {1'b0, thr});
			write_reg(REG_STRAIGHT_LOW, IDX_W'(lo));
			tx_style = $urandom_range(2, 0);
			rx_style = $urandom_range(2, 0);

			if (ph == 4) begin
				// reader holds off while short rows keep coming, so the block fills
				tx_style = 0;
				hold_req = 1'b1;
				while (phase_words < 100)
					queue_row($urandom_range(2, 0), $urandom_range(1, 0) ? 1 : -1, 1'b1);
			end else begin
				while (phase_words < 100) begin
					case ($urandom_range(9, 0))
						0, 1, 2: queue_row($urandom_range(30, 0), -1, 1'b1);
						default: begin
							case ($urandom_range(6, 0))
								0: target = lo - 1;
								1: target = lo;
								2: target = lo + 1;
								3: target = hi - 1;
								4: target = hi;
								5: target = hi + 1;
								default: target = $urandom_range(40, 1);
							endcase
							if (target < 1)
								target = 1;
							if (target > 60)
								target = 60;
							queue_row(target + 1 + $urandom_range(4, 0), target,
								($urandom_range(1, 0) == 1));
						end
					endcase
				end
			end
			drain();
		end

		// reset-value thresholds with long rows: straight, right, and a saturated column
		write_reg(REG_BLACK_THRESHOLD, {1'b0, BLACK_THRESHOLD_RST});
		write_reg(REG_STRAIGHT_LOW, STRAIGHT_LOW_RST);
		write_reg(REG_STRAIGHT_HIGH, STRAIGHT_HIGH_RST);
		tx_style = 2;
		rx_style = 1;
		queue_row(165, 160, 1'b0);
		queue_row(195, 190, 1'b0);
		queue_row(520, 515, 1'b0);
		queue_row(20, -1, 1'b1);
		drain();

		if (mismatches == 0 && expected_rows.size() == 0)
			$display("line_position_detector_unit verification clean");
		else
			$display("line_position_detector_unit verification failed");
		$finish;
	end

endmodule
